[design/npc_pkg.sv]
// Package for the nearest palette color search block.
// Holds sizes, command codes and the sequencer state type; depends on nothing.
package npc_pkg;

   // Palette depth, 2 to 256 entries.
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_ADDR_W  = (PAL_ENTRIES > 2) ? $clog2(PAL_ENTRIES) : 1;

   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 10;
   localparam int ENTRY_W = 3 * CHAN_W;

   // Command codes carried on the func field.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } npc_state_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

[design/nearest_palette_color_top.sv]
// Nearest palette color search, top level: palette memory, scan sequencer and
// the shared distance/compare unit. Depends on npc_pkg.
//
// A write (func = 0) stores one RGB palette entry; writes to an index at or
// above the palette depth are dropped. A query (func = 1) scans every palette
// entry through one distance unit, one entry per cycle, and returns the index
// with the smallest sum of absolute channel differences (the highest index on
// ties) together with that sum. A query occupies the block from its transfer
// until the result is offered, as entries pass one at a time through the
// single read port of the palette memory and its registered read; req_ready
// stays low until the result transfer completes.
// The palette reads as zero after reset; a valid bit per entry stands in for
// clearing the memory, so no clearing pass is needed.
module nearest_palette_color_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [npc_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [npc_pkg::CHAN_W-1:0]  req_red,
   input  logic [npc_pkg::CHAN_W-1:0]  req_green,
   input  logic [npc_pkg::CHAN_W-1:0]  req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [npc_pkg::INDEX_W-1:0] rsp_color_index,
   output logic [npc_pkg::DIST_W-1:0]  rsp_distance
);
   import npc_pkg::*;

   logic [ENTRY_W-1:0]    pal_mem [PAL_ENTRIES];
   logic                  entry_vld_ff [PAL_ENTRIES];

   npc_state_type         state_ff, state_in;
   logic [CHAN_W-1:0]     pix_r_ff, pix_g_ff, pix_b_ff;

   logic [PAL_ADDR_W-1:0] issue_ff, issue_in;
   logic                  issue_act_ff, issue_act_in;
   logic                  issue_last;

   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  rd_vld_ff;
   logic                  cmp_vld_ff;
   logic                  cmp_last_ff;
   logic [PAL_ADDR_W-1:0] cmp_idx_ff;

   logic [PAL_ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;

   logic                  req_xfer, rsp_xfer, wr_en;
   logic [ENTRY_W-1:0]    entry;
   logic [DIST_W-1:0]     cur_dist;
   logic                  take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign wr_en = req_xfer && (req_func == FUNC_WRITE)
                  && ({1'b0, req_entry_index} < (INDEX_W + 1)'(PAL_ENTRIES));

   assign issue_last = (issue_ff == PAL_ADDR_W'(PAL_ENTRIES - 1));

   // Palette memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[req_entry_index[PAL_ADDR_W-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_data_ff <= pal_mem[issue_ff];
   end

   // Entry valid bits; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            entry_vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_vld_ff[req_entry_index[PAL_ADDR_W-1:0]] <= 1'b1;
         end
         rd_vld_ff <= entry_vld_ff[issue_ff];
      end
   end

   // Shared distance unit on the registered read data.
   assign entry    = rd_vld_ff ? rd_data_ff : '0;
   assign cur_dist = DIST_W'(abs_diff(pix_r_ff, entry[3*CHAN_W-1:2*CHAN_W]))
                   + DIST_W'(abs_diff(pix_g_ff, entry[2*CHAN_W-1:CHAN_W]))
                   + DIST_W'(abs_diff(pix_b_ff, entry[CHAN_W-1:0]));
   // Entry zero always wins its compare; later ties replace the best.
   assign take     = (cmp_idx_ff == '0) || (cur_dist <= best_dist_ff);

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      issue_act_in = issue_act_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_func == FUNC_QUERY)) begin
               state_in     = ST_SCAN;
               issue_in     = '0;
               issue_act_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (issue_act_ff) begin
               issue_in = issue_ff + PAL_ADDR_W'(1);
               if (issue_last) begin
                  issue_act_in = 1'b0;
               end
            end
            if (cmp_vld_ff && take) begin
               best_idx_in  = cmp_idx_ff;
               best_dist_in = cur_dist;
            end
            if (cmp_vld_ff && cmp_last_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         issue_act_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         cmp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         issue_act_ff <= issue_act_in;
         cmp_vld_ff   <= issue_act_ff && (state_ff == ST_SCAN);
         cmp_last_ff  <= issue_last;
      end
   end

   // Payload registers: pixel under query, compare index, best so far.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
      end
      cmp_idx_ff   <= issue_ff;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
   end

   assign rsp_color_index = INDEX_W'(best_idx_ff);
   assign rsp_distance    = best_dist_ff;

endmodule
